// ----- rtl/mbt_pkg.sv -----
package mbt_pkg;

    localparam int MBT_WEIGHT_BITS     = 20;
    localparam int MBT_SIGMOID_ENTRIES = 256;

    // Width of the narrow operand of the shared multiplier.
    localparam int B_BITS    = 14;
    localparam int STEP_BITS = 5;

    localparam logic [12:0] Q12_ONE  = 13'd4096;
    localparam logic [12:0] LR_RESET = 13'd410;

    localparam logic [STEP_BITS-1:0] STEP_LAST_INFER = 5'd6;
    localparam logic [STEP_BITS-1:0] STEP_LAST_TRAIN = 5'd29;

    localparam logic [1:0] OP_TRAIN = 2'd0;
    localparam logic [1:0] OP_INFER = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [3:0] PIDX_HW0 = 4'd0;
    localparam logic [3:0] PIDX_HW1 = 4'd1;
    localparam logic [3:0] PIDX_HW2 = 4'd2;
    localparam logic [3:0] PIDX_HW3 = 4'd3;
    localparam logic [3:0] PIDX_HB0 = 4'd4;
    localparam logic [3:0] PIDX_HB1 = 4'd5;
    localparam logic [3:0] PIDX_OW0 = 4'd6;
    localparam logic [3:0] PIDX_OW1 = 4'd7;
    localparam logic [3:0] PIDX_OB  = 4'd8;

    typedef enum logic [3:0] {
        A_ZERO, A_HW0, A_HW1, A_HW2, A_HW3, A_H0, A_H1, A_OW0, A_OW1,
        A_O, A_PS12, A_PROD, A_DOUT, A_DH0, A_DH1
    } a_sel_t;

    typedef enum logic [3:0] {
        B_ZERO, B_X0, B_X1, B_H0, B_H1, B_H0C, B_H1C, B_OMO, B_TMO,
        B_DOUT, B_DSH0, B_DSH1, B_LR
    } b_sel_t;

    typedef enum logic [4:0] {
        ACT_NONE, ACT_ACC, ACT_H0, ACT_H1, ACT_OUT, ACT_DOUT, ACT_DSH0,
        ACT_DSH1, ACT_DH0, ACT_DH1, ACT_UOB, ACT_UOW0, ACT_UOW1, ACT_UHB0,
        ACT_UHB1, ACT_UHW0, ACT_UHW1, ACT_UHW2, ACT_UHW3
    } act_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        act_t   act;
    } uop_t;

    typedef struct packed {
        logic                 run;
        logic [STEP_BITS-1:0] step;
        logic                 finish;
    } seq_ctrl_t;

    // Each step multiplies two operands and consumes the product of the step before.
    function automatic uop_t mbt_uop(input logic [STEP_BITS-1:0] step);
        uop_t u;
        unique case (step)
            5'd0:  u = '{A_HW0,  B_X0,   ACT_NONE};
            5'd1:  u = '{A_HW2,  B_X1,   ACT_ACC};
            5'd2:  u = '{A_HW1,  B_X0,   ACT_H0};
            5'd3:  u = '{A_HW3,  B_X1,   ACT_ACC};
            5'd4:  u = '{A_OW0,  B_H0,   ACT_H1};
            5'd5:  u = '{A_OW1,  B_H1,   ACT_ACC};
            5'd6:  u = '{A_H0,   B_H0C,  ACT_OUT};
            5'd7:  u = '{A_O,    B_OMO,  ACT_DSH0};
            5'd8:  u = '{A_PS12, B_TMO,  ACT_NONE};
            5'd9:  u = '{A_H1,   B_H1C,  ACT_DOUT};
            5'd10: u = '{A_OW0,  B_DOUT, ACT_DSH1};
            5'd11: u = '{A_PS12, B_DSH0, ACT_NONE};
            5'd12: u = '{A_OW1,  B_DOUT, ACT_DH0};
            5'd13: u = '{A_PS12, B_DSH1, ACT_NONE};
            5'd14: u = '{A_DOUT, B_LR,   ACT_DH1};
            5'd15: u = '{A_H0,   B_DOUT, ACT_UOB};
            5'd16: u = '{A_PROD, B_LR,   ACT_NONE};
            5'd17: u = '{A_H1,   B_DOUT, ACT_UOW0};
            5'd18: u = '{A_PROD, B_LR,   ACT_NONE};
            5'd19: u = '{A_DH0,  B_LR,   ACT_UOW1};
            5'd20: u = '{A_DH0,  B_X0,   ACT_UHB0};
            5'd21: u = '{A_PROD, B_LR,   ACT_NONE};
            5'd22: u = '{A_DH0,  B_X1,   ACT_UHW0};
            5'd23: u = '{A_PROD, B_LR,   ACT_NONE};
            5'd24: u = '{A_DH1,  B_LR,   ACT_UHW2};
            5'd25: u = '{A_DH1,  B_X0,   ACT_UHB1};
            5'd26: u = '{A_PROD, B_LR,   ACT_NONE};
            5'd27: u = '{A_DH1,  B_X1,   ACT_UHW1};
            5'd28: u = '{A_PROD, B_LR,   ACT_NONE};
            5'd29: u = '{A_ZERO, B_ZERO, ACT_UHW3};
            default: u = '{A_ZERO, B_ZERO, ACT_NONE};
        endcase
        return u;
    endfunction

    function automatic logic [12:0] clamp_q12(input logic [12:0] v);
        return (v > Q12_ONE) ? Q12_ONE : v;
    endfunction

    // Restoring shift-and-subtract quotient, used only while building the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One sigmoid table entry, evaluated at elaboration only.
    function automatic logic [12:0] sig_entry(input int e, input longint step);
        longint      x;
        longint      sum;
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] y;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        int          k;
        x    = -longint'(524288) + longint'(e) * step;
        a    = (x < 0) ? 64'(-x) : 64'(x);
        t    = a << 10;
        sum  = longint'(1) << 30;
        term = 64'd1 << 30;
        for (k = 1; k <= 12; k++)
        begin
            term = udiv64((term * t) >> 30, 64'(k));
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        y = 64'(sum);
        for (k = 0; k < 4; k++)
            y = (y * y) >> 30;
        den = (64'd1 << 30) + y;
        num = (x >= 0) ? (64'd4096 << 30) : (64'd4096 * y);
        q   = udiv64(num + (den >> 1), den);
        return q[12:0];
    endfunction

endpackage

// ----- rtl/mbt_mul.sv -----
module mbt_mul #(
    parameter int AW = 29,
    parameter int BW = 14
) (
    input  logic                 clk,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] prod_reg
);

    logic signed [AW+BW-1:0] prod_next;

    assign prod_next = (AW+BW)'(a) * (AW+BW)'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ----- rtl/mbt_sigmoid.sv -----
module mbt_sigmoid #(
    parameter int ZW              = 43,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic signed [ZW-1:0] z,
    output logic [12:0]          y
);
    import mbt_pkg::*;

    localparam int     IW       = $clog2(SIGMOID_ENTRIES);
    localparam longint TabStep  = 1048576 / SIGMOID_ENTRIES;

    logic [12:0]            tab [SIGMOID_ENTRIES];
    logic signed [ZW:0]     s;
    logic [16+IW-1:0]       scaled;
    logic [IW-1:0]          idx;

    for (genvar e = 0; e < SIGMOID_ENTRIES; e++) begin : g_tab
        localparam logic [12:0] Val = sig_entry(e, TabStep);
        assign tab[e] = Val;
    end

    // Offset by 8.0 so the table spans [-8, 8); outside it the end entries hold.
    assign s      = (ZW+1)'(z) + (ZW+1)'(32768);
    assign scaled = (16+IW)'(s[15:0]) * (16+IW)'(SIGMOID_ENTRIES);
    assign idx    = scaled[16+IW-1:16];

    always_comb
    begin
        if (s <= 0)
            y = tab[0];
        else if (s >= (ZW+1)'(65536))
            y = tab[SIGMOID_ENTRIES-1];
        else
            y = tab[idx];
    end

endmodule

// ----- rtl/mbt_seq.sv -----
module mbt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          opcode,
    input  logic                out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output mbt_pkg::seq_ctrl_t  ctrl
);
    import mbt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [STEP_BITS-1:0] last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 finish;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign finish      = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    assign ctrl.run    = (state_reg == ST_RUN);
    assign ctrl.step   = step_reg;
    assign ctrl.finish = finish;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    step_next = '0;
                    if (opcode == OP_TRAIN)
                    begin
                        last_next  = STEP_LAST_TRAIN;
                        state_next = ST_RUN;
                    end
                    else if (opcode == OP_INFER)
                    begin
                        last_next  = STEP_LAST_INFER;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == last_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= last_reg))
        else $error("step counter ran past the last step");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid)
        else $error("finished word not presented");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second word while busy");
`endif

endmodule

// ----- rtl/mlp_backprop_trainer_2_2_1_unit.sv -----
// Channel   Handshake             Word
// cfg       cfg_valid/cfg_ready   learn_rate
// in        in_valid/in_ready     opcode, feature_a, feature_b, target, param_index, param_value
// out       out_valid/out_ready   net_output, saturated
//
// A training word runs 30 steps of the shared multiplier and an inference word 7; the result
// register is then loaded. The single multiplier and the one-word sequencer mean that the
// next word is taken only when the sequencer is idle.
// The result register holds its word until taken; the block waits in its finish state meanwhile.
// Reset clears all weights and biases to zero and sets the learning rate to its default.
module mlp_backprop_trainer_2_2_1_unit #(
    parameter int WEIGHT_BITS     = mbt_pkg::MBT_WEIGHT_BITS,
    parameter int SIGMOID_ENTRIES = mbt_pkg::MBT_SIGMOID_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        learn_rate,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [12:0]        feature_a,
    input  logic [12:0]        feature_b,
    input  logic [12:0]        target,
    input  logic [3:0]         param_index,
    input  logic signed [19:0] param_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [12:0]        net_output,
    output logic               saturated
);
    import mbt_pkg::*;

    localparam int W  = WEIGHT_BITS;
    localparam int AW = W + 9;
    localparam int BW = B_BITS;
    localparam int PW = AW + BW;

    localparam logic signed [PW-1:0] WMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] WMIN = ~WMAX;

    seq_ctrl_t ctrl;
    uop_t      uop;
    logic      accept;

    logic signed [W-1:0]  hw_reg [4];
    logic signed [W-1:0]  hb_reg [2];
    logic signed [W-1:0]  ow_reg [2];
    logic signed [W-1:0]  ob_reg;
    logic [12:0]          lr_reg;
    logic                 sat_reg;

    logic [12:0]          x0_reg, x1_reg, tgt_reg;
    logic [1:0]           op_reg;
    logic signed [PW-1:0] acc_reg;
    logic [12:0]          h0_reg, h1_reg, o_reg;
    logic signed [BW-1:0] dout_reg, dsh0_reg, dsh1_reg;
    logic signed [AW-1:0] dh0_reg, dh1_reg;
    logic [12:0]          net_output_reg;
    logic                 saturated_reg;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [12:0]          lr_eff;

    logic signed [PW-1:0] zsum;
    logic signed [PW-1:0] zbias;
    logic signed [PW-1:0] z;
    logic [12:0]          sig_y;

    logic signed [W-1:0]  upd_cur;
    logic signed [PW-1:0] upd_delta;
    logic signed [PW-1:0] upd_sum;
    logic signed [W-1:0]  upd_val;
    logic                 upd_clip;
    logic                 upd_act;
    logic                 upd_short;

    logic signed [PW-1:0] load_ext;
    logic signed [W-1:0]  load_val;

    assign cfg_ready  = 1'b1;
    assign accept     = in_valid && in_ready;
    assign net_output = net_output_reg;
    assign saturated  = saturated_reg;
    assign lr_eff     = clamp_q12(lr_reg);
    assign uop        = ctrl.run ? mbt_uop(ctrl.step) : '{A_ZERO, B_ZERO, ACT_NONE};

    mbt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    mbt_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    mbt_sigmoid #(
        .ZW              (PW),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_sigmoid (
        .z (z),
        .y (sig_y)
    );

    always_comb
    begin
        unique case (uop.a_sel)
            A_HW0:   mul_a = AW'(hw_reg[0]);
            A_HW1:   mul_a = AW'(hw_reg[1]);
            A_HW2:   mul_a = AW'(hw_reg[2]);
            A_HW3:   mul_a = AW'(hw_reg[3]);
            A_H0:    mul_a = $signed({{(AW-13){1'b0}}, h0_reg});
            A_H1:    mul_a = $signed({{(AW-13){1'b0}}, h1_reg});
            A_OW0:   mul_a = AW'(ow_reg[0]);
            A_OW1:   mul_a = AW'(ow_reg[1]);
            A_O:     mul_a = $signed({{(AW-13){1'b0}}, o_reg});
            A_PS12:  mul_a = AW'(prod >>> 12);
            A_PROD:  mul_a = AW'(prod);
            A_DOUT:  mul_a = AW'(dout_reg);
            A_DH0:   mul_a = dh0_reg;
            A_DH1:   mul_a = dh1_reg;
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (uop.b_sel)
            B_X0:    mul_b = $signed({1'b0, x0_reg});
            B_X1:    mul_b = $signed({1'b0, x1_reg});
            B_H0:    mul_b = $signed({1'b0, h0_reg});
            B_H1:    mul_b = $signed({1'b0, h1_reg});
            B_H0C:   mul_b = $signed({1'b0, 13'(Q12_ONE - h0_reg)});
            B_H1C:   mul_b = $signed({1'b0, 13'(Q12_ONE - h1_reg)});
            B_OMO:   mul_b = $signed({1'b0, 13'(Q12_ONE - o_reg)});
            B_TMO:   mul_b = $signed({1'b0, tgt_reg}) - $signed({1'b0, o_reg});
            B_DOUT:  mul_b = dout_reg;
            B_DSH0:  mul_b = dsh0_reg;
            B_DSH1:  mul_b = dsh1_reg;
            B_LR:    mul_b = $signed({1'b0, lr_eff});
            default: mul_b = '0;
        endcase
    end

    // Pre-activation of a neuron: bias plus the floored sum of its two products.
    assign zsum = acc_reg + prod;
    always_comb
    begin
        unique case (uop.act)
            ACT_H1:  zbias = PW'(hb_reg[1]);
            ACT_OUT: zbias = PW'(ob_reg);
            default: zbias = PW'(hb_reg[0]);
        endcase
    end
    assign z = zbias + (zsum >>> 12);

    always_comb
    begin
        upd_act   = 1'b1;
        upd_short = 1'b0;
        unique case (uop.act)
            ACT_UOB:
            begin
                upd_cur   = ob_reg;
                upd_short = 1'b1;
            end
            ACT_UOW0: upd_cur = ow_reg[0];
            ACT_UOW1: upd_cur = ow_reg[1];
            ACT_UHB0:
            begin
                upd_cur   = hb_reg[0];
                upd_short = 1'b1;
            end
            ACT_UHB1:
            begin
                upd_cur   = hb_reg[1];
                upd_short = 1'b1;
            end
            ACT_UHW0: upd_cur = hw_reg[0];
            ACT_UHW1: upd_cur = hw_reg[1];
            ACT_UHW2: upd_cur = hw_reg[2];
            ACT_UHW3: upd_cur = hw_reg[3];
            default:
            begin
                upd_cur = '0;
                upd_act = 1'b0;
            end
        endcase
    end

    // Bias steps carry one factor of 4096 less than weight steps.
    assign upd_delta = upd_short ? (prod >>> 12) : (prod >>> 24);
    assign upd_sum   = PW'(upd_cur) + upd_delta;
    assign upd_clip  = (upd_sum > WMAX) || (upd_sum < WMIN);
    assign upd_val   = (upd_sum > WMAX) ? W'(WMAX) :
                       (upd_sum < WMIN) ? W'(WMIN) : W'(upd_sum);

    assign load_ext = PW'(param_value);
    assign load_val = (load_ext > WMAX) ? W'(WMAX) :
                      (load_ext < WMIN) ? W'(WMIN) : W'(load_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg[0] <= '0;
            hw_reg[1] <= '0;
            hw_reg[2] <= '0;
            hw_reg[3] <= '0;
            hb_reg[0] <= '0;
            hb_reg[1] <= '0;
            ow_reg[0] <= '0;
            ow_reg[1] <= '0;
            ob_reg    <= '0;
        end
        else if (accept && (opcode == OP_LOAD))
        begin
            unique case (param_index)
                PIDX_HW0: hw_reg[0] <= load_val;
                PIDX_HW1: hw_reg[1] <= load_val;
                PIDX_HW2: hw_reg[2] <= load_val;
                PIDX_HW3: hw_reg[3] <= load_val;
                PIDX_HB0: hb_reg[0] <= load_val;
                PIDX_HB1: hb_reg[1] <= load_val;
                PIDX_OW0: ow_reg[0] <= load_val;
                PIDX_OW1: ow_reg[1] <= load_val;
                PIDX_OB:  ob_reg    <= load_val;
                default:  ;
            endcase
        end
        else
        begin
            unique case (uop.act)
                ACT_UOB:  ob_reg    <= upd_val;
                ACT_UOW0: ow_reg[0] <= upd_val;
                ACT_UOW1: ow_reg[1] <= upd_val;
                ACT_UHB0: hb_reg[0] <= upd_val;
                ACT_UHB1: hb_reg[1] <= upd_val;
                ACT_UHW0: hw_reg[0] <= upd_val;
                ACT_UHW1: hw_reg[1] <= upd_val;
                ACT_UHW2: hw_reg[2] <= upd_val;
                ACT_UHW3: hw_reg[3] <= upd_val;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                lr_reg <= learn_rate;
            if (accept)
                sat_reg <= 1'b0;
            else if (upd_act && upd_clip)
                sat_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg  <= clamp_q12(feature_a);
            x1_reg  <= clamp_q12(feature_b);
            tgt_reg <= clamp_q12(target);
            op_reg  <= opcode;
        end
        unique case (uop.act)
            ACT_ACC:  acc_reg  <= prod;
            ACT_H0:   h0_reg   <= sig_y;
            ACT_H1:   h1_reg   <= sig_y;
            ACT_OUT:  o_reg    <= sig_y;
            ACT_DOUT: dout_reg <= BW'(prod >>> 12);
            ACT_DSH0: dsh0_reg <= BW'(prod >>> 12);
            ACT_DSH1: dsh1_reg <= BW'(prod >>> 12);
            ACT_DH0:  dh0_reg  <= AW'(prod >>> 12);
            ACT_DH1:  dh1_reg  <= AW'(prod >>> 12);
            default:  ;
        endcase
        if (ctrl.finish)
        begin
            net_output_reg <= ((op_reg == OP_TRAIN) || (op_reg == OP_INFER)) ? o_reg : '0;
            saturated_reg  <= (op_reg == OP_TRAIN) ? sat_reg : 1'b0;
        end
    end

endmodule

// ----- test/tb_mlp_backprop_trainer_2_2_1_unit.sv -----
module tb_mlp_backprop_trainer_2_2_1_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mbt_pkg::*;

    localparam int  WB        = MBT_WEIGHT_BITS;
    localparam int  ENTRIES   = MBT_SIGMOID_ENTRIES;
    localparam int  N_DIRECT  = 20;
    localparam int  N_RANDOM  = 235;
    localparam int  CYCLE_CAP = 600000;
    localparam logic [3:0] PIDX_BAD = 4'd9;
    localparam logic [3:0] PIDX_TOP = 4'd15;

    typedef struct {
        logic [1:0]         op;
        logic [12:0]        fa;
        logic [12:0]        fb;
        logic [12:0]        tgt;
        logic [3:0]         idx;
        logic signed [19:0] val;
        bit                 known;
        logic [12:0]        net;
        logic               sat;
    } stim_t;

    typedef struct {
        logic [12:0] net;
        logic        sat;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [12:0]        learn_rate;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [12:0]        feature_a;
    logic [12:0]        feature_b;
    logic [12:0]        target;
    logic [3:0]         param_index;
    logic signed [19:0] param_value;
    logic               out_valid;
    logic               out_ready;
    logic [12:0]        net_output;
    logic               saturated;

    mlp_backprop_trainer_2_2_1_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .learn_rate  (learn_rate),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .feature_a   (feature_a),
        .feature_b   (feature_b),
        .target      (target),
        .param_index (param_index),
        .param_value (param_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .net_output  (net_output),
        .saturated   (saturated)
    );

    // Shadow copy of the network and the learning rate.
    longint      hw [4];
    longint      hb [2];
    longint      ow [2];
    longint      ob;
    logic [12:0] rate;
    longint      sig_lut [ENTRIES];

    answer_t     pending [$];
    int          send_idle;
    int          recv_idle;
    int          mismatches;
    int          cycles;
    stim_t       directed [N_DIRECT];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint sat_weight(input longint v, inout bit clip);
        longint hi;
        hi = (longint'(1) << (WB - 1)) - 1;
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < -hi - 1) begin
            clip = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint limit_q12(input logic [12:0] v);
        return (v > 13'd4096) ? 64'sd4096 : longint'(v);
    endfunction

    // exp(-|x|) comes from a series through the 12th power at |x|/16, squared four times.
    function automatic void fill_sigmoid();
        longint      x;
        longint      acc;
        logic [63:0] mag;
        logic [63:0] arg;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        for (int i = 0; i < ENTRIES; i++) begin
            x    = -64'sd524288 + longint'(i) * longint'(1048576 / ENTRIES);
            mag  = (x < 0) ? -x : x;
            arg  = mag << 10;
            acc  = longint'(1) << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 12; k++) begin
                term = ((term * arg) >> 30) / k;
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            e = acc;
            for (int k = 0; k < 4; k++)
                e = (e * e) >> 30;
            den = (64'd1 << 30) + e;
            num = (x >= 0) ? (64'd4096 << 30) : 64'd4096 * e;
            sig_lut[i] = longint'((num + den / 2) / den);
        end
    endfunction

    function automatic longint sigmoid(input longint z);
        longint s;
        s = z + 32768;
        if (s <= 0)
            return sig_lut[0];
        if (s >= 65536)
            return sig_lut[ENTRIES - 1];
        return sig_lut[(s * ENTRIES) >>> 16];
    endfunction

    function automatic longint slope(input longint y);
        return (y * (4096 - y)) >>> 12;
    endfunction

    // Runs one word through the shadow network and returns the result it should produce.
    function automatic answer_t run_network(input stim_t s);
        answer_t r;
        longint  x [2];
        longint  h [2];
        longint  dh [2];
        longint  y;
        longint  tg;
        longint  lr;
        longint  d_out;
        bit      clip;
        r.net = '0;
        r.sat = 1'b0;
        clip  = 1'b0;
        if (s.op == OP_LOAD) begin
            y = sat_weight(longint'(s.val), clip);
            if (s.idx <= PIDX_HW3)
                hw[s.idx] = y;
            else if (s.idx <= PIDX_HB1)
                hb[s.idx - PIDX_HB0] = y;
            else if (s.idx <= PIDX_OW1)
                ow[s.idx - PIDX_OW0] = y;
            else if (s.idx == PIDX_OB)
                ob = y;
            return r;
        end
        if (s.op == OP_NONE)
            return r;
        x[0] = limit_q12(s.fa);
        x[1] = limit_q12(s.fb);
        tg   = limit_q12(s.tgt);
        for (int j = 0; j < 2; j++)
            h[j] = sigmoid(hb[j] + ((x[0] * hw[j] + x[1] * hw[2 + j]) >>> 12));
        y     = sigmoid(ob + ((h[0] * ow[0] + h[1] * ow[1]) >>> 12));
        r.net = y[12:0];
        if (s.op == OP_INFER)
            return r;
        lr    = limit_q12(rate);
        d_out = ((tg - y) * slope(y)) >>> 12;
        for (int j = 0; j < 2; j++)
            dh[j] = (((d_out * ow[j]) >>> 12) * slope(h[j])) >>> 12;
        ob = sat_weight(ob + ((d_out * lr) >>> 12), clip);
        for (int j = 0; j < 2; j++)
            ow[j] = sat_weight(ow[j] + ((h[j] * d_out * lr) >>> 24), clip);
        for (int j = 0; j < 2; j++) begin
            hb[j] = sat_weight(hb[j] + ((dh[j] * lr) >>> 12), clip);
            for (int k = 0; k < 2; k++)
                hw[k * 2 + j] = sat_weight(hw[k * 2 + j] + ((x[k] * dh[j] * lr) >>> 24), clip);
        end
        r.sat = clip;
        return r;
    endfunction

    task automatic push_word(input stim_t s);
        answer_t r;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= s.op;
        feature_a   <= s.fa;
        feature_b   <= s.fb;
        target      <= s.tgt;
        param_index <= s.idx;
        param_value <= s.val;
        do
            @(posedge clk);
        while (!in_ready);
        r = run_network(s);
        if (s.known) begin
            r.net = s.net;
            r.sat = s.sat;
        end
        pending.push_back(r);
    endtask

    task automatic set_rate(input logic [12:0] v);
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid  <= 1'b1;
        learn_rate <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate = v;
    endtask

    function automatic logic [12:0] pick_q12();
        case ($urandom_range(9))
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'($urandom_range(8191));
            default: return 13'($urandom_range(4096));
        endcase
    endfunction

    function automatic stim_t random_word();
        stim_t s;
        int    pick;
        s.known = 1'b0;
        s.net   = '0;
        s.sat   = 1'b0;
        s.fa    = pick_q12();
        s.fb    = pick_q12();
        s.tgt   = pick_q12();
        s.idx   = 4'($urandom_range(8));
        s.val   = 20'($urandom_range(16383)) - 20'sd8192;
        pick    = $urandom_range(99);
        if (pick < 50)
            s.op = OP_TRAIN;
        else if (pick < 70)
            s.op = OP_INFER;
        else if (pick < 95)
            s.op = OP_LOAD;
        else
            s.op = OP_NONE;
        if ($urandom_range(9) == 0)
            s.idx = 4'($urandom_range(15));
        case ($urandom_range(9))
            0: s.val = 20'sh7FFFF;
            1: s.val = -20'sh80000;
            2: s.val = 20'($urandom);
            default: ;
        endcase
        return s;
    endfunction

    always @(posedge clk) begin
        answer_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("mlp_backprop_trainer_2_2_1_unit regression: fail");
            $finish;
        end
        if (rst_n && out_valid && out_ready) begin
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: net_output=%0d saturated=%0d",
                             net_output, saturated);
            end else begin
                want = pending.pop_front();
                if (net_output !== want.net || saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected net_output=%0d saturated=%0d, got %0d %0d",
                                 want.net, want.sat, net_output, saturated);
                end
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        logic [12:0] rates [4];
        cycles      = 0;
        mismatches  = 0;
        send_idle   = 36;
        recv_idle   = 76;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        learn_rate  = '0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        opcode      = OP_NONE;
        feature_a   = '0;
        feature_b   = '0;
        target      = '0;
        param_index = '0;
        param_value = '0;
        fill_sigmoid();
        hw   = '{0, 0, 0, 0};
        hb   = '{0, 0};
        ow   = '{0, 0};
        ob   = 0;
        rate = LR_RESET;

        // With all weights zero every node sits at the middle of the sigmoid.
        directed = '{
            '{OP_INFER, 13'd0,    13'd0,    13'd0,    PIDX_HW0, 20'sd0,      1, 13'd2048, 0},
            '{OP_NONE,  13'd4096, 13'd4096, 13'd4096, PIDX_OB,  20'sd5,      1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_BAD, 20'sd12345,  1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_TOP, -20'sd777,   1, 13'd0,    0},
            '{OP_INFER, 13'd4096, 13'd4096, 13'd0,    PIDX_HW0, 20'sd0,      1, 13'd2048, 0},
            '{OP_TRAIN, 13'd4096, 13'd4096, 13'd4096, PIDX_HW0, 20'sd0,      0, 13'd0,    0},
            '{OP_TRAIN, 13'd8191, 13'd8191, 13'd8191, PIDX_HW0, 20'sd0,      0, 13'd0,    0},
            '{OP_TRAIN, 13'd0,    13'd4096, 13'd0,    PIDX_HW0, 20'sd0,      0, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_HW0, 20'sd8192,   1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_HW1, -20'sd8192,  1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_HW2, 20'sd4096,   1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_HW3, -20'sd2048,  1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_HB0, 20'sd1000,   1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_HB1, -20'sd3000,  1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_OW0, 20'sh7FFFF,  1, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_OW1, -20'sh80000, 1, 13'd0,    0},
            '{OP_INFER, 13'd4096, 13'd0,    13'd0,    PIDX_HW0, 20'sd0,      0, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_OB,  20'sh7FFFF,  1, 13'd0,    0},
            '{OP_TRAIN, 13'd4096, 13'd4096, 13'd0,    PIDX_HW0, 20'sd0,      0, 13'd0,    0},
            '{OP_LOAD,  13'd0,    13'd0,    13'd0,    PIDX_OB,  -20'sh80000, 1, 13'd0,    0}
        };
        rates = '{13'd4096, 13'd0, 13'd8191, 13'($urandom_range(1, 4095))};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECT; i++)
            push_word(directed[i]);

        for (int seg = 0; seg < 4; seg++) begin
            set_rate(rates[seg]);
            if (seg == 1) begin
                send_idle = 76;
                recv_idle = 36;
            end else if (seg >= 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int i = 0; i < N_RANDOM; i++)
                push_word(random_word());
        end
        in_valid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("mlp_backprop_trainer_2_2_1_unit regression: pass");
        else
            $display("mlp_backprop_trainer_2_2_1_unit regression: fail");
        $finish;
    end

endmodule
